FILE: hdl/sosc_pkg.sv
package sosc_pkg;

  // Sine table geometry: one full period of TABLE_SIZE entries, phase in
  // entries with FRAC_W fractional bits.
  localparam int TABLE_SIZE = 1024;
  localparam int IDX_W      = 10;
  localparam int FRAC_W     = 16;
  localparam int PHASE_W    = IDX_W + FRAC_W;

  // Quarter-wave table: entries 0 .. TABLE_SIZE/4 inclusive.
  localparam int QTR      = TABLE_SIZE / 4;
  localparam int HALF     = TABLE_SIZE / 2;
  localparam int TQTR     = 3 * TABLE_SIZE / 4;
  localparam int QS_DEPTH = QTR + 1;
  localparam int QS_W     = $clog2(QS_DEPTH);
  localparam int MAG_W    = 15;

  localparam int SAMPLE_W = 16;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  // Taylor terms k = 1..10
  localparam int N_TERMS = 10;

  typedef logic [QS_DEPTH-1:0][MAG_W-1:0] qsine_tab_t;
  typedef logic signed [SAMPLE_W-1:0]     sample_t;

  // round(32767 * sin(j * pi / (2 * QTR))), Q30 series; elaboration only
  function automatic qsine_tab_t build_qsine();
    qsine_tab_t        tab;
    longint unsigned   x;
    longint unsigned   term;
    longint unsigned   v;
    longint            sum;
    int                j;
    int                k;
    for (j = 0; j < QS_DEPTH; j++) begin
      x    = (64'(4 * j) * PI_HALF_Q30) / TABLE_SIZE;
      term = x;
      sum  = longint'(x);
      for (k = 1; k <= N_TERMS; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        // divisor (2k)(2k+1)
        term = term / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = ($unsigned(sum) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[j] = MAG_W'(v);
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

  // Full-period sine entry from the quarter-wave table.
  function automatic sample_t sine_at(input logic [IDX_W-1:0] i);
    int               ii;
    logic [QS_W-1:0]  j;
    logic             neg;
    sample_t          mag;
    ii = int'(i);
    priority if (ii <= QTR) begin
      j   = QS_W'(ii);
      neg = 1'b0;
    end else if (ii <= HALF) begin
      j   = QS_W'(HALF - ii);
      neg = 1'b0;
    end else if (ii <= TQTR) begin
      j   = QS_W'(ii - HALF);
      neg = 1'b1;
    end else begin
      j   = QS_W'(TABLE_SIZE - ii);
      neg = 1'b1;
    end
    mag = $signed({1'b0, QSINE[j]});
    return neg ? -mag : mag;
  endfunction

endpackage

FILE: hdl/sosc_ram.sv
module sosc_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hdl/sine_oscillator_bank_core.sv
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    partial_i, amplitude_i, frequency_i, active_i
// out      output     out_valid_o / out_stall_i  sample_o
// cfg      input      APB write/read             paddr, pwdata, prdata (32 bit)
//
// One word per cycle enters and leaves while in_stall_o and out_stall_i are low; each sample
// passes the phase RAM read, the multiply stages and the rounding stage to the output register.
// After reset the phase RAM is cleared one entry a cycle, all NUM_PARTIALS entries,
// with in_stall_o high; config writes are taken throughout.
// A stalled output parks one more sample in a skid register; only when that is
// full does the pipeline freeze and in_stall_o rise.
module sine_oscillator_bank_core
  import sosc_pkg::*;
#(
  parameter int NUM_PARTIALS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input words
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           partial_i,
  input  logic [15:0]          amplitude_i,
  input  logic signed [23:0]   frequency_i,
  input  logic                 active_i,
  // output words
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   sample_o,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int AW = (NUM_PARTIALS > 1) ? $clog2(NUM_PARTIALS) : 1;

  // register index, taken from paddr[2]
  localparam logic REG_TPH  = 1'b0;
  localparam logic REG_GAIN = 1'b1;

  localparam logic [31:0] TPH_RESET  = 32'd99728941;
  localparam logic [15:0] GAIN_RESET = 16'd4096;

  localparam logic signed [48:0] RND_HALF = 49'sd134217728;  // 2^27
  localparam logic signed [20:0] SAT_MAX  = 21'sd32767;
  localparam logic signed [20:0] SAT_MIN  = -21'sd32768;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] tph_q;
  logic [15:0] gain_q;
  logic        cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tph_q  <= TPH_RESET;
      gain_q <= GAIN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TPH:  tph_q  <= pwdata;
        REG_GAIN: gain_q <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TPH:  prdata = tph_q;
      REG_GAIN: prdata = {16'd0, gain_q};
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Clearing pass over the phase RAM after reset
  // ---------------------------------------------------------------------------
  logic          clr_busy_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == AW'(NUM_PARTIALS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline advance
  // ---------------------------------------------------------------------------
  logic skid_v_q;
  logic out_v_q;
  logic pipe_adv;
  logic in_accept;
  logic in_range;

  // whole pipeline moves in lock step; only a full skid stops it
  assign pipe_adv   = ~skid_v_q;
  assign in_stall_o = clr_busy_q | skid_v_q;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign in_range   = int'(partial_i) < NUM_PARTIALS;

  // ---------------------------------------------------------------------------
  // Phase RAM
  // ---------------------------------------------------------------------------
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [PHASE_W-1:0] ram_wdata;
  logic [PHASE_W-1:0] ram_rdata;

  // stage valids and payload
  logic               v1_q, v2_q, v3_q, v4_q;
  logic               act1_q, act2_q, act3_q, act4_q;
  logic [AW-1:0]      p1_q, p2_q, p3_q;
  logic [15:0]        amp1_q, amp2_q;
  logic signed [23:0] freq1_q;
  logic [PHASE_W-1:0] ph2_q, ph3_q;
  logic [PHASE_W-1:0] inc2_q;
  logic signed [15:0] s0_2_q, s1_2_q;
  logic [FRAC_W-1:0]  frac2_q;
  logic signed [15:0] interp3_q;
  logic [31:0]        ag3_q;
  logic signed [48:0] acc4_q;

  logic [PHASE_W-1:0] nph2;
  logic               wr2;

  assign wr2       = v2_q & act2_q & pipe_adv;
  assign ram_we    = clr_busy_q | wr2;
  assign ram_waddr = clr_busy_q ? clr_cnt_q : p2_q;
  assign ram_wdata = clr_busy_q ? '0 : nph2;

  sosc_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (NUM_PARTIALS)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (AW'(partial_i)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (pipe_adv) begin
      v1_q <= in_accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: phase from RAM or forwarded, table lookup, increment multiply
  // ---------------------------------------------------------------------------
  // The word one stage ahead has not written yet, and the word two ahead wrote
  // on the same edge this read was taken; both are forwarded, nearest first.
  logic [PHASE_W-1:0] ph_fwd;
  logic [IDX_W-1:0]   idx1, nxt1;
  logic signed [56:0] prod1;
  logic               fwd2, fwd3;

  assign fwd2 = v2_q & act2_q & (p2_q == p1_q);
  assign fwd3 = v3_q & act3_q & (p3_q == p1_q);

  always_comb begin
    priority if (fwd2) begin
      ph_fwd = nph2;
    end else if (fwd3) begin
      ph_fwd = ph3_q;
    end else begin
      ph_fwd = ram_rdata;
    end
  end

  assign idx1  = ph_fwd[PHASE_W-1:FRAC_W];
  assign nxt1  = idx1 + IDX_W'(1);  // wraps at the table end
  assign prod1 = freq1_q * $signed({1'b0, tph_q});

  // ---------------------------------------------------------------------------
  // Stage 2: interpolation multiply, amplitude x gain, phase write-back
  // ---------------------------------------------------------------------------
  logic signed [16:0] diff2;
  logic signed [33:0] mprod2;
  logic signed [17:0] sum2;

  assign diff2  = 17'(s1_2_q) - 17'(s0_2_q);
  assign mprod2 = diff2 * $signed({1'b0, frac2_q});
  // floor of the product over 2^16 is its upper bits
  assign sum2   = 18'(s0_2_q) + mprod2[33:16];
  // increment floor(prod / 2^24) taken mod the period
  assign nph2   = ph2_q + inc2_q;

  // ---------------------------------------------------------------------------
  // Stage 3: scale; stage 4: round half up and saturate
  // ---------------------------------------------------------------------------
  logic signed [48:0] acc3;
  logic signed [48:0] rnd4;
  logic signed [20:0] sh4;
  sample_t            sample_d;

  assign acc3 = interp3_q * $signed({1'b0, ag3_q});
  assign rnd4 = acc4_q + RND_HALF;
  assign sh4  = rnd4[48:28];

  always_comb begin
    priority if (!act4_q) begin
      sample_d = '0;
    end else if (sh4 > SAT_MAX) begin
      sample_d = SAT_MAX[15:0];
    end else if (sh4 < SAT_MIN) begin
      sample_d = SAT_MIN[15:0];
    end else begin
      sample_d = sh4[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      act1_q    <= active_i & in_range;
      p1_q      <= AW'(partial_i);
      amp1_q    <= amplitude_i;
      freq1_q   <= frequency_i;

      act2_q    <= act1_q;
      p2_q      <= p1_q;
      amp2_q    <= amp1_q;
      ph2_q     <= ph_fwd;
      inc2_q    <= prod1[PHASE_W+23:24];
      s0_2_q    <= sine_at(idx1);
      s1_2_q    <= sine_at(nxt1);
      frac2_q   <= ph_fwd[FRAC_W-1:0];

      act3_q    <= act2_q;
      p3_q      <= p2_q;
      ph3_q     <= nph2;
      interp3_q <= sum2[15:0];
      ag3_q     <= 32'(amp2_q) * 32'(gain_q);

      act4_q    <= act3_q;
      acc4_q    <= acc3;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid
  // ---------------------------------------------------------------------------
  sample_t out_q, skid_q;
  logic    push, out_pop;

  assign push    = v4_q & pipe_adv;
  assign out_pop = out_v_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_q || out_pop) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_v_q || out_pop) begin
        out_q <= sample_d;
      end else begin
        skid_q <= sample_d;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign sample_o    = out_q;

`ifndef SYNTH
  // pipeline stays empty while the RAM is being cleared
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !(v1_q || v2_q || v3_q || v4_q))
    else $error("word in flight during phase RAM clear");

  // skid only ever backs up a held output word
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a word while output is empty");

  // skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_valid_o && out_stall_i))
    else $error("skid filled without an output stall");

  // no phase write-back while the pipeline is frozen
  a_frozen_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !clr_busy_q) |-> !ram_we)
    else $error("phase written while pipeline frozen");
`endif

endmodule
